[hw/rtl/spq_pkg.sv]
// Package for the sorted priority queue: entry and result types, mode codes.
// No dependencies; used by the interfaces, the entry RAM and the top level.
package spq_pkg;

  // Mode codes of an input item
  localparam logic ModeInsert = 1'b0;
  localparam logic ModeRemove = 1'b1;

  // Default queue depth
  localparam int unsigned QueueDepthDefault = 16;

  // Width of the result's occupancy field
  localparam int unsigned OccW = 5;

  // One stored entry
  typedef struct packed {
    logic signed [31:0] value;
    logic        [15:0] prio;
  } spq_entry_t;

  localparam int unsigned EntryW = $bits(spq_entry_t);

  // One result item
  typedef struct packed {
    logic               popped_valid;
    logic signed [31:0] popped_value;
    logic        [15:0] popped_priority;
    logic               was_empty;
    logic               insert_dropped;
    logic [OccW-1:0]    occupancy;
  } spq_result_t;

endpackage

[hw/rtl/spq_if.sv]
// Handshake interfaces for the input and result channels of the queue.
// Depends on spq_pkg.
interface spq_in_if
  import spq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] item_value;
  logic        [15:0] item_priority;

  modport source (output valid, mode, item_value, item_priority, input ready);
  modport sink   (input valid, mode, item_value, item_priority, output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               popped_valid;
  logic signed [31:0] popped_value;
  logic        [15:0] popped_priority;
  logic               was_empty;
  logic               insert_dropped;
  logic [OccW-1:0]    occupancy;

  modport source (output valid, popped_valid, popped_value, popped_priority, was_empty,
                  insert_dropped, occupancy, input ready);
  modport sink   (input valid, popped_valid, popped_value, popped_priority, was_empty,
                  insert_dropped, occupancy, output ready);
endinterface

[hw/rtl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: sequencer, circular pointers, result register.
// Depends on spq_pkg, spq_if (spq_in_if, spq_out_if) and spq_ram.
//
//  channel | dir | handshake          | payload
//  in_i    | in  | valid / ready      | mode, item_value, item_priority
//  out_o   | out | valid / ready      | popped_valid, popped_value, popped_priority,
//          |     |                    | was_empty, insert_dropped, occupancy
//
// Entries sit in a circular buffer in priority order. in_i.ready rises at the same edge
// that raises out_o.valid, so the next item cannot be taken before the result is
// registered. A remove reads the head through the registered RAM port, then forms the
// result. An insert moves each entry with a greater priority up one slot: each move is
// one RAM read and one compare-and-write. The scan ends at the first entry that does not
// move, whose compare writes the new entry; when every entry moves, or the queue is
// empty, that last compare is skipped and the new entry is written directly. Full
// inserts and empty removes go straight to the result. No clearing pass follows reset.
// The result register lets one result wait while the next item is taken; a further
// result waits in the sequencer until the register frees.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    IDLE,
    POP_RD,
    POP_OUT,
    INS_RD,
    INS_CMP,
    INS_PUT,
    RESULT
  } state_e;

  state_e      state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] rem_q, rem_d;
  spq_entry_t  new_q, new_d;
  spq_result_t pend_q, pend_d;
  spq_result_t out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  spq_entry_t        ram_wdata;
  logic [EntryW-1:0] ram_rdata_raw;
  spq_entry_t        ram_rdata;
  logic              in_fire;
  logic              ins_done;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LastIdx : p - 1'b1;
  endfunction

  spq_ram #(
    .DEPTH(QUEUE_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  assign ram_rdata = spq_entry_t'(ram_rdata_raw);
  assign in_i.ready = (state_q == IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // sequencer: shared compare against the entry read last cycle
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    rem_d       = rem_q;
    new_d       = new_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = cursor_q;
    ram_wdata   = new_q;
    ram_re      = 1'b0;
    ram_raddr   = ptr_dec(cursor_q);
    ins_done    = 1'b0;

    unique case (state_q)
      IDLE: begin
        if (in_fire) begin
          pend_d = '0;
          new_d  = '{value: in_i.item_value, prio: in_i.item_priority};
          if (in_i.mode == ModeInsert) begin
            cursor_d = tail_q;
            rem_d    = count_q;
            if (count_q == FullCnt) begin
              pend_d.insert_dropped = 1'b1;
              pend_d.occupancy      = OccW'(count_q);
              state_d               = RESULT;
            end else if (count_q == '0) begin
              state_d = INS_PUT;
            end else begin
              state_d = INS_RD;
            end
          end else begin
            if (count_q == '0) begin
              pend_d.was_empty = 1'b1;
              pend_d.occupancy = OccW'(count_q);
              state_d          = RESULT;
            end else begin
              state_d = POP_RD;
            end
          end
        end
      end
      POP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = head_q;
        state_d   = POP_OUT;
      end
      POP_OUT: begin
        pend_d.popped_valid    = 1'b1;
        pend_d.popped_value    = ram_rdata.value;
        pend_d.popped_priority = ram_rdata.prio;
        pend_d.occupancy       = OccW'(count_q - 1'b1);
        head_d                 = ptr_inc(head_q);
        count_d                = count_q - 1'b1;
        state_d                = RESULT;
      end
      INS_RD: begin
        ram_re  = 1'b1;
        state_d = INS_CMP;
      end
      INS_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata.prio > new_q.prio) begin
          // move the greater entry up one slot
          ram_wdata = ram_rdata;
          cursor_d  = ptr_dec(cursor_q);
          rem_d     = rem_q - 1'b1;
          state_d   = (rem_q == CW'(1)) ? INS_PUT : INS_RD;
        end else begin
          ins_done = 1'b1;
        end
      end
      INS_PUT: begin
        ram_we   = 1'b1;
        ins_done = 1'b1;
      end
      RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase

    // insert finished: new entry written at the cursor this cycle
    if (ins_done) begin
      tail_d           = ptr_inc(tail_q);
      count_d          = count_q + 1'b1;
      pend_d.occupancy = OccW'(count_q + 1'b1);
      state_d          = RESULT;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      cursor_q    <= '0;
      rem_q       <= '0;
      new_q       <= '0;
      pend_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      rem_q       <= rem_d;
      new_q       <= new_d;
      pend_q      <= pend_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result channel
  assign out_o.valid           = out_valid_q;
  assign out_o.popped_valid    = out_q.popped_valid;
  assign out_o.popped_value    = out_q.popped_value;
  assign out_o.popped_priority = out_q.popped_priority;
  assign out_o.was_empty       = out_q.was_empty;
  assign out_o.insert_dropped  = out_q.insert_dropped;
  assign out_o.occupancy       = out_q.occupancy;

`ifndef SYNTH
  // entry count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("entry count above queue depth");

  // an insert into a full queue leaves the count alone and is flagged
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.mode == ModeInsert && count_q == FullCnt)
    |=> (count_q == $past(count_q) && pend_q.insert_dropped))
    else $error("full insert not dropped");

  // the shift loop only runs with entries left to look at
  a_rem_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == INS_RD || state_q == INS_CMP) |-> rem_q != '0)
    else $error("insert scan past the head");

  // a pending result waits while the result register is blocked
  a_result_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == RESULT && out_valid_q && !out_o.ready) |=> state_q == RESULT)
    else $error("result overwrote a waiting item");
`endif

endmodule

[hw/rtl/spq_ram.sv]
// Entry store of the queue: one write port, one read port, registered read data.
// Depends on spq_pkg.
module spq_ram
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDefault,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [EntryW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [EntryW-1:0] rdata_o
);

  logic [EntryW-1:0] mem_q [DEPTH];
  logic [EntryW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
